// ===== rtl/sha256_byte_hasher_macros.svh =====
// ----------------------------------------------------------------------------
// sha256 byte hasher assertion macros
// Concurrent check macros used by the hasher controller, removable as a set.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_HASHER_MACROS_SVH
`define SHA256_BYTE_HASHER_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define SHABH_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define SHABH_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SHABH_ASSERT(label, clk, rst, prop, msg)
`define SHABH_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/shabh_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256 byte hasher package
// Constants, tables and controller/datapath command types.
// ----------------------------------------------------------------------------
package shabh_pkg;

  localparam int BLOCK_BYTES  = 64;
  localparam int LENGTH_POS   = 56;
  localparam int ROUNDS       = 64;
  localparam int DIGEST_WORDS = 8;
  localparam logic [7:0] PAD_MARK = 8'h80;

  // input mode codes
  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam logic [31:0] INIT_HASH [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // source of the byte shifted into the block
  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_MARK = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic      shift;      // shift one byte into the block
    byte_sel_t sel;
    logic      sched;      // one message schedule step
    logic [5:0] step;      // schedule step index
    logic      load_work;  // copy hash words into working vars
    logic      round;      // one compression round
    logic      hash_add;   // fold working vars into hash words
    logic      hash_init;  // restart message
    logic [2:0] word_idx;  // digest word on the output
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } status_t;

endpackage

// ===== rtl/shabh_in_if.sv =====
// ----------------------------------------------------------------------------
// sha256 byte hasher input channel
// Valid/ready channel carrying one message byte or a finish request.
// ----------------------------------------------------------------------------
interface shabh_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

// ===== rtl/shabh_out_if.sv =====
// ----------------------------------------------------------------------------
// sha256 byte hasher output channel
// Valid/ready channel carrying one digest word per transfer.
// ----------------------------------------------------------------------------
interface shabh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        word_last;

  modport source (output valid, output digest_word, output word_last, input ready);
  modport sink   (input valid, input digest_word, input word_last, output ready);
endinterface

// ===== rtl/shabh_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha256 byte hasher controller
// Sequences byte loading, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
`include "sha256_byte_hasher_macros.svh"

module shabh_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               msg_valid,
  input  logic               msg_mode,
  output logic               msg_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_last,
  input  shabh_pkg::status_t status,
  output shabh_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [5:0] FILL_LAST = 6'(shabh_pkg::BLOCK_BYTES - 1);
  localparam logic [5:0] FILL_LEN  = 6'(shabh_pkg::LENGTH_POS);
  localparam logic [6:0] CNT_LAST  = 7'(shabh_pkg::ROUNDS);
  localparam logic [2:0] WORD_LAST = 3'(shabh_pkg::DIGEST_WORDS - 1);

  logic [2:0] state, state_next;
  logic [6:0] cnt, cnt_next;
  logic       marked, marked_next;
  logic       last_blk, last_blk_next;
  logic [2:0] widx, widx_next;
  logic       msg_xfer;

  assign msg_ready = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign out_last  = (widx == WORD_LAST);
  assign msg_xfer  = msg_valid && msg_ready;

  // next state and command decode
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    marked_next   = marked;
    last_blk_next = last_blk;
    widx_next     = widx;
    cmd           = '0;
    cmd.sel       = shabh_pkg::SEL_DATA;
    cmd.step      = cnt[5:0];
    cmd.word_idx  = widx;
    unique case (state)
      S_IDLE: begin
        if (msg_xfer) begin
          if (msg_mode == shabh_pkg::MODE_ABSORB) begin
            cmd.shift = 1'b1;
            if (status.fill == FILL_LAST) begin
              state_next = S_COMP;
              cnt_next   = '0;
            end
          end else begin
            state_next    = S_PAD;
            marked_next   = 1'b0;
            last_blk_next = 1'b0;
          end
        end
      end
      S_PAD: begin
        cmd.shift = 1'b1;
        if (!marked) begin
          cmd.sel       = shabh_pkg::SEL_MARK;
          marked_next   = 1'b1;
          last_blk_next = (status.fill < FILL_LEN);
        end else if (last_blk && (status.fill >= FILL_LEN)) begin
          cmd.sel = shabh_pkg::SEL_LEN;
        end else begin
          cmd.sel = shabh_pkg::SEL_ZERO;
        end
        if (status.fill == FILL_LAST) begin
          state_next = S_COMP;
          cnt_next   = '0;
        end
      end
      S_COMP: begin
        cmd.sched     = !cnt[6];
        cmd.load_work = (cnt == '0);
        cmd.round     = (cnt != '0);
        cnt_next      = cnt + 7'd1;
        if (cnt == CNT_LAST) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.hash_add = 1'b1;
        if (!marked) begin
          state_next = S_IDLE;
        end else if (last_blk) begin
          state_next = S_EMIT;
          widx_next  = '0;
        end else begin
          // extra block: zeros then the length
          state_next    = S_PAD;
          last_blk_next = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          widx_next = widx + 3'd1;
          if (widx == WORD_LAST) begin
            cmd.hash_init = 1'b1;
            state_next    = S_IDLE;
            marked_next   = 1'b0;
            last_blk_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      marked   <= 1'b0;
      last_blk <= 1'b0;
      widx     <= '0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      marked   <= marked_next;
      last_blk <= last_blk_next;
      widx     <= widx_next;
    end
  end

  // checks
  `SHABH_ASSERT_NEVER(a_in_out_excl, clk, rst, msg_ready && out_valid, "input and output both open")
  `SHABH_ASSERT(a_finish_pads, clk, rst, (msg_xfer && msg_mode == shabh_pkg::MODE_FINISH) |=> (state == S_PAD), "finish did not start padding")
  `SHABH_ASSERT(a_comp_len, clk, rst, (state == S_COMP && cnt == CNT_LAST) |=> (state == S_ADD), "compression did not end after last round")
  `SHABH_ASSERT(a_emit_end, clk, rst, (out_valid && out_ready && out_last) |=> (msg_ready && !out_valid), "digest did not end on last word")
  `SHABH_ASSERT(a_emit_last, clk, rst, (state == S_ADD && marked && last_blk) |=> (out_valid && widx == '0), "digest did not start at word zero")

endmodule

// ===== rtl/shabh_datapath.sv =====
// ----------------------------------------------------------------------------
// sha256 byte hasher datapath
// Block shift register, message schedule, round unit and hash words.
// ----------------------------------------------------------------------------
module shabh_datapath (
  input  logic               clk,
  input  logic               rst,
  input  shabh_pkg::cmd_t    cmd,
  input  logic [7:0]         data_byte,
  output shabh_pkg::status_t status,
  output logic [31:0]        digest_word
);

  logic [31:0] hash [shabh_pkg::DIGEST_WORDS];
  logic [31:0] work [8];
  logic [31:0] win  [16];
  logic [31:0] wk;
  logic [5:0]  fill;
  logic [63:0] msg_bytes;
  logic [63:0] bit_len;
  logic [2:0]  len_idx;
  logic [7:0]  in_byte;
  logic [31:0] w_new;
  logic [31:0] t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  assign status.fill = fill;
  assign digest_word = hash[cmd.word_idx];

  // byte source: message, pad mark, zero or big-endian bit length
  assign bit_len = {msg_bytes[60:0], 3'b000};
  assign len_idx = 3'd7 - fill[2:0];
  always_comb begin
    unique case (cmd.sel)
      shabh_pkg::SEL_DATA: in_byte = data_byte;
      shabh_pkg::SEL_MARK: in_byte = shabh_pkg::PAD_MARK;
      shabh_pkg::SEL_ZERO: in_byte = '0;
      shabh_pkg::SEL_LEN:  in_byte = bit_len[{len_idx, 3'b000} +: 8];
      default:             in_byte = '0;
    endcase
  end

  // fill and length counters
  always_ff @(posedge clk) begin
    if (rst || cmd.hash_init) begin
      fill      <= '0;
      msg_bytes <= '0;
    end else if (cmd.shift) begin
      fill <= fill + 6'd1;
      if (cmd.sel == shabh_pkg::SEL_DATA) begin
        msg_bytes <= msg_bytes + 64'd1;
      end
    end
  end

  // message schedule: block words first, then the expansion
  always_comb begin
    if (cmd.step[5:4] == 2'b00) begin
      w_new = win[0];
    end else begin
      w_new = win[0] + ssig0(win[1]) + win[9] + ssig1(win[14]);
    end
  end

  // block bytes and schedule share one 16-word window
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[15] <= {win[15][23:0], in_byte};
    end else if (cmd.sched) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
      wk      <= w_new + shabh_pkg::ROUND_K[cmd.step];
    end
  end

  // round unit
  assign t1 = work[7] + bsig1(work[4]) + ((work[4] & work[5]) ^ (~work[4] & work[6])) + wk;
  assign t2 = bsig0(work[0]) +
              ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) begin
        work[i] <= hash[i];
      end
    end else if (cmd.round) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  // hash words
  always_ff @(posedge clk) begin
    if (rst || cmd.hash_init) begin
      for (int i = 0; i < shabh_pkg::DIGEST_WORDS; i++) begin
        hash[i] <= shabh_pkg::INIT_HASH[i];
      end
    end else if (cmd.hash_add) begin
      for (int i = 0; i < shabh_pkg::DIGEST_WORDS; i++) begin
        hash[i] <= hash[i] + work[i];
      end
    end
  end

endmodule

// ===== rtl/sha256_byte_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256 byte hasher
// Absorb takes one byte per cycle while ready is high; a byte that fills the
// block runs the single round unit with schedule prefetch, then the hash add.
// Finish pads one byte per cycle to the block end and compresses each block
// (one or two blocks), then eight output transfers of one digest word each.
// Synchronous reset loads the initial hash values and clears fill and length.
// ----------------------------------------------------------------------------
module sha256_byte_hasher (
  input  logic        clk,
  input  logic        rst,
  shabh_in_if.sink    msg,
  shabh_out_if.source digest
);

  shabh_pkg::cmd_t    cmd;
  shabh_pkg::status_t status;
  logic               ready;
  logic               valid;
  logic               last;
  logic [31:0]        word;

  // sequencing
  shabh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg.valid),
    .msg_mode  (msg.mode),
    .msg_ready (ready),
    .out_valid (valid),
    .out_ready (digest.ready),
    .out_last  (last),
    .status    (status),
    .cmd       (cmd)
  );

  // hashing datapath
  shabh_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (msg.data_byte),
    .status      (status),
    .digest_word (word)
  );

  // channel hookup
  assign msg.ready          = ready;
  assign digest.valid       = valid;
  assign digest.word_last   = last;
  assign digest.digest_word = word;

endmodule
